FILE: design/pixel_layer_blend_compose_unit_defines.svh
// assertion macros for the pixel layer blend compositor
`ifndef PIXEL_LAYER_BLEND_COMPOSE_UNIT_DEFINES_SVH
`define PIXEL_LAYER_BLEND_COMPOSE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PLBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("plbc assertion failed");

// next-cycle implication, checked out of reset
`define PLBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plbc assertion failed");

`endif

FILE: design/plbc_pkg.sv
// types, constants and the channel mix function of the pixel compositor
`timescale 1ns / 1ps
`default_nettype none

package plbc_pkg;

  localparam int unsigned ColorW = 15;
  localparam int unsigned ChanW  = 5;
  localparam int unsigned CoefW  = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [ColorW-1:0] ColorWhite = 15'h7fff;
  localparam logic [ColorW-1:0] ColorBlack = 15'h0000;
  localparam logic [CoefW-1:0]  CoefMax    = 5'h10;
  localparam logic [ChanW-1:0]  ChanMax    = 5'h1f;

  typedef enum logic [1:0] {
    ModeOff   = 2'd0,
    ModeAlpha = 2'd1,
    ModeWhite = 2'd2,
    ModeBlack = 2'd3
  } blend_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBlendMode    = 3'd0,
    CfgCoefFirst    = 3'd1,
    CfgCoefSecond   = 3'd2,
    CfgFadeAmount   = 3'd3,
    CfgBackdrop     = 3'd4,
    CfgBdFirstTgt   = 3'd5,
    CfgBdSecondTgt  = 3'd6
  } cfg_idx_e;

  // first member sits in the highest bits: matches the tuser layout
  typedef struct packed {
    logic       second_blends;
    logic       top_blends;
    logic [1:0] layer_count;
  } pix_flags_t;

  function automatic logic [CoefW-1:0] clamp_coef(logic [CoefW-1:0] v);
    return (v > CoefMax) ? CoefMax : v;
  endfunction

  // per channel (a*wa + b*wb) >> 4, saturated at 31
  function automatic logic [ColorW-1:0] mix_color(logic [ColorW-1:0] a,
                                                  logic [ColorW-1:0] b,
                                                  logic [CoefW-1:0]  wa,
                                                  logic [CoefW-1:0]  wb);
    logic [ColorW-1:0] res;
    logic [10:0]       sum;
    logic [6:0]        shr;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = ({6'b0, a[ch*ChanW +: ChanW]} * {6'b0, wa}) +
            ({6'b0, b[ch*ChanW +: ChanW]} * {6'b0, wb});
      shr = sum[10:4];
      res[ch*ChanW +: ChanW] = (|shr[6:5]) ? ChanMax : shr[ChanW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/pixel_layer_blend_compose_unit.sv
// pixel compositor: layer blend and fade, one pixel per cycle while the output is not stalled
// pipeline: two register stages, the input register and then the result register
// throughput: one word per cycle unless the output stalls; each register holds one word
// the blend is six 5x5 products (two per channel) and a saturating add between the registers
// reset: rst_ni async active low clears valid flags and all config registers to zero
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_layer_blend_compose_unit_defines.svh"

module pixel_layer_blend_compose_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [plbc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [plbc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // [14:0] top_color, [29:15] second_color, [31:30] zero
  input  wire logic [31:0]                   s_axis_tdata,
  // [1:0] layer_count, [2] top_blends, [3] second_blends
  input  wire logic [3:0]                    s_axis_tuser,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [14:0] out_color, [15] zero
  output      logic [15:0]                   m_axis_tdata
);
  import plbc_pkg::*;

  // config registers
  logic [1:0]        mode_q;
  logic [CoefW-1:0]  coef_first_q, coef_second_q, fade_q;
  logic [ColorW-1:0] bd_color_q;
  logic              bd_first_q, bd_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= '0;
      coef_first_q  <= '0;
      coef_second_q <= '0;
      fade_q        <= '0;
      bd_color_q    <= '0;
      bd_first_q    <= 1'b0;
      bd_second_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBlendMode:   mode_q        <= cfg_data_i[1:0];
        CfgCoefFirst:   coef_first_q  <= cfg_data_i[CoefW-1:0];
        CfgCoefSecond:  coef_second_q <= cfg_data_i[CoefW-1:0];
        CfgFadeAmount:  fade_q        <= cfg_data_i[CoefW-1:0];
        CfgBackdrop:    bd_color_q    <= cfg_data_i[ColorW-1:0];
        CfgBdFirstTgt:  bd_first_q    <= cfg_data_i[0];
        CfgBdSecondTgt: bd_second_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic              in_valid_q;
  logic [ColorW-1:0] top_q, second_q;
  pix_flags_t        flags_q;
  logic              out_valid_q;
  logic [ColorW-1:0] out_color_q;
  logic [ColorW-1:0] out_color_d;
  logic              out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      top_q    <= s_axis_tdata[14:0];
      second_q <= s_axis_tdata[29:15];
      flags_q  <= s_axis_tuser;
    end
  end

  // blend select and mix
  logic              covered, resolved;
  logic [CoefW-1:0]  eva, evb, evy;
  logic [ColorW-1:0] base, mix_a, mix_b;
  logic [CoefW-1:0]  wa, wb;
  logic              do_mix;

  always_comb begin
    covered  = |flags_q.layer_count;
    resolved = flags_q.layer_count[1];
    eva      = clamp_coef(coef_first_q);
    evb      = clamp_coef(coef_second_q);
    evy      = clamp_coef(fade_q);
    base     = covered ? top_q : bd_color_q;
    mix_a    = base;
    mix_b    = resolved ? second_q : bd_color_q;
    wa       = eva;
    wb       = evb;
    do_mix   = 1'b0;
    case (mode_q)
      ModeOff: begin
        do_mix = 1'b0;
      end
      ModeAlpha: begin
        if (resolved) begin
          do_mix = flags_q.top_blends && flags_q.second_blends;
        end else if (covered) begin
          do_mix = flags_q.top_blends && bd_second_q;
        end
      end
      ModeWhite, ModeBlack: begin
        mix_b  = (mode_q == ModeWhite) ? ColorWhite : ColorBlack;
        wa     = CoefMax - evy;
        wb     = evy;
        do_mix = covered ? flags_q.top_blends : bd_first_q;
      end
      default: ;
    endcase
    out_color_d = do_mix ? mix_color(mix_a, mix_b, wa, wb) : base;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) begin
      out_color_q <= out_color_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_color_q};

  `PLBC_ASSERT_NEXT(a_word_moves_to_output, in_valid_q && out_free, out_valid_q)
  `PLBC_ASSERT_NEXT(a_stalled_word_kept, in_valid_q && !out_free, in_valid_q)
  `PLBC_ASSERT_NOW(a_ready_when_output_free, !out_valid_q, s_axis_tready)

endmodule

`default_nettype wire

FILE: dv/pixel_compose_checker.sv
// checker for the pixel compositor: mirrors config, predicts each pixel, compares results
`timescale 1ns / 1ps

module pixel_compose_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [plbc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [plbc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // [14:0] top_color, [29:15] second_color, [31:30] zero
  input  logic [31:0]                   s_axis_tdata,
  // [1:0] layer_count, [2] top_blends, [3] second_blends
  input  logic [3:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [14:0] out_color, [15] zero
  input  logic [15:0]                   m_axis_tdata,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   compared_o
);
  import plbc_pkg::*;

  blend_mode_e mode_q;
  logic [4:0]  coef_first_q;
  logic [4:0]  coef_second_q;
  logic [4:0]  fade_q;
  logic [14:0] backdrop_q;
  logic        bd_first_q;
  logic        bd_second_q;

  logic [14:0] expected_colors[$];

  function automatic int unsigned weight16(logic [4:0] w);
    return (w > 5'd16) ? 16 : int'(w);
  endfunction

  // per channel weighted sum in sixteenths, saturating at full scale
  function automatic logic [14:0] mix_rgb(logic [14:0] a, logic [14:0] b,
                                          int unsigned wa, int unsigned wb);
    logic [14:0] res;
    int unsigned c;
    for (int ch = 0; ch < 3; ch++) begin
      c = (int'(a[ch*5 +: 5]) * wa + int'(b[ch*5 +: 5]) * wb) >> 4;
      res[ch*5 +: 5] = (c > 31) ? 5'd31 : c[4:0];
    end
    return res;
  endfunction

  function automatic logic [14:0] compose_pixel(logic [1:0] count_in, logic [14:0] top,
                                                logic top_first, logic [14:0] second,
                                                logic second_tgt);
    logic [1:0]  count;
    logic [14:0] base;
    logic        is_first;
    int unsigned evy;
    count = (count_in == 2'd3) ? 2'd2 : count_in;
    evy = weight16(fade_q);
    case (mode_q)
      ModeOff: begin
        return (count != 0) ? top : backdrop_q;
      end
      ModeAlpha: begin
        if (count == 0) return backdrop_q;
        // a lone top layer may only blend against the backdrop
        if (count == 1)
          return (top_first && bd_second_q)
            ? mix_rgb(top, backdrop_q, weight16(coef_first_q), weight16(coef_second_q))
            : top;
        return (top_first && second_tgt)
          ? mix_rgb(top, second, weight16(coef_first_q), weight16(coef_second_q))
          : top;
      end
      default: begin
        base = (count != 0) ? top : backdrop_q;
        is_first = (count != 0) ? top_first : bd_first_q;
        if (!is_first) return base;
        return mix_rgb(base, (mode_q == ModeWhite) ? ColorWhite : ColorBlack, 16 - evy, evy);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [14:0] want;
    if (!rst_ni) begin
      mode_q        <= ModeOff;
      coef_first_q  <= '0;
      coef_second_q <= '0;
      fade_q        <= '0;
      backdrop_q    <= '0;
      bd_first_q    <= 1'b0;
      bd_second_q   <= 1'b0;
      expected_colors.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
      compared_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgBlendMode:   mode_q        <= blend_mode_e'(cfg_data_i[1:0]);
          CfgCoefFirst:   coef_first_q  <= cfg_data_i[4:0];
          CfgCoefSecond:  coef_second_q <= cfg_data_i[4:0];
          CfgFadeAmount:  fade_q        <= cfg_data_i[4:0];
          CfgBackdrop:    backdrop_q    <= cfg_data_i[14:0];
          CfgBdFirstTgt:  bd_first_q    <= cfg_data_i[0];
          CfgBdSecondTgt: bd_second_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected result word: out_color actual %h", m_axis_tdata[14:0]);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_colors.pop_front();
          compared_o <= compared_o + 1;
          if (m_axis_tdata[14:0] !== want) begin
            $error("out_color mismatch: expected %h actual %h", want, m_axis_tdata[14:0]);
            fail_count_o <= fail_count_o + 1;
          end else if (m_axis_tdata[15] !== 1'b0) begin
            $error("tdata pad mismatch: expected 0 actual %b", m_axis_tdata[15]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_colors.push_back(compose_pixel(s_axis_tuser[1:0], s_axis_tdata[14:0],
                                                s_axis_tuser[2], s_axis_tdata[29:15],
                                                s_axis_tuser[3]));
      pending_o <= expected_colors.size();
    end
  end

endmodule

FILE: dv/tb.sv
// testbench top for the pixel compositor: clock, reset, config phases, pixel stimulus, verdict
`timescale 1ns / 1ps

module tb;
  import plbc_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic [3:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned compared;

  bit src_calm;
  bit sink_calm;
  int unsigned settings_run;

  pixel_layer_blend_compose_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  pixel_compose_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .compared_o(compared)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall before each word, none while calm
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_pixel(logic [1:0] count, logic [14:0] top, logic top_first,
                            logic [14:0] second, logic second_tgt);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, second, top};
    s_axis_tuser  <= {second_tgt, top_first, count};
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
  endtask

  // drain all expected words, then let the two-stage pipe settle
  task automatic drain(int unsigned limit);
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0 && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic load_settings(blend_mode_e mode, logic [4:0] wa, logic [4:0] wb,
                               logic [4:0] evy, logic [14:0] backdrop, logic bd_first,
                               logic bd_second);
    write_reg(CfgBlendMode, CfgDataW'(mode));
    write_reg(CfgCoefFirst, CfgDataW'(wa));
    write_reg(CfgCoefSecond, CfgDataW'(wb));
    write_reg(CfgFadeAmount, CfgDataW'(evy));
    write_reg(CfgBackdrop, backdrop);
    write_reg(CfgBdFirstTgt, CfgDataW'(bd_first));
    write_reg(CfgBdSecondTgt, CfgDataW'(bd_second));
    settings_run++;
  endtask

  // extremes of each field, every layer count and flag mix
  task automatic directed_pixels();
    send_pixel(2'd0, 15'h7fff, 1'b1, 15'h7fff, 1'b1);
    send_pixel(2'd1, 15'h7fff, 1'b1, 15'h0000, 1'b0);
    send_pixel(2'd1, 15'h1234, 1'b0, 15'h7fff, 1'b1);
    send_pixel(2'd2, 15'h7fff, 1'b1, 15'h7fff, 1'b1);
    send_pixel(2'd2, 15'h0000, 1'b1, 15'h0000, 1'b1);
    send_pixel(2'd2, 15'h7c00, 1'b1, 15'h03e0, 1'b0);
    send_pixel(2'd2, 15'h001f, 1'b0, 15'h7fff, 1'b1);
    send_pixel(2'd3, 15'h5555, 1'b1, 15'h2aaa, 1'b1);
    send_pixel(2'd3, 15'h2aaa, 1'b0, 15'h5555, 1'b0);
    send_pixel(2'd1, 15'h03e0, 1'b1, 15'h7c00, 1'b1);
    send_pixel(2'd0, 15'h0000, 1'b0, 15'h0000, 1'b0);
    send_pixel(2'd2, 15'h7fff, 1'b1, 15'h001f, 1'b1);
  endtask

  function automatic logic [4:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [14:0] pick_color();
    case ($urandom_range(0, 7))
      0: return 15'h0000;
      1: return 15'h7fff;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  initial begin
    settings_run = 0;
    src_calm = 1'b0;
    sink_calm = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings first: everything off, backdrop black
    send_pixel(2'd0, 15'h7fff, 1'b1, 15'h7fff, 1'b1);
    send_pixel(2'd2, 15'h4321, 1'b1, 15'h1234, 1'b1);
    drain(1000);

    // weights above sixteen clamp, backdrop as partner of a lone top
    load_settings(ModeAlpha, 5'd31, 5'd16, 5'd31, 15'h7fff, 1'b1, 1'b1);
    directed_pixels();
    drain(1000);

    load_settings(ModeWhite, 5'd0, 5'd0, 5'd31, 15'h1234, 1'b0, 1'b0);
    directed_pixels();
    drain(1000);

    for (int p = 0; p < 8; p++) begin
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      load_settings(blend_mode_e'(p % 4), pick_weight(), pick_weight(), pick_weight(),
                    pick_color(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      repeat (50)
        send_pixel(2'($urandom_range(0, 3)), pick_color(), 1'($urandom_range(0, 1)),
                   pick_color(), 1'($urandom_range(0, 1)));
      drain(1000);
    end

    if (pending != 0) begin
      $error("%0d expected out_color words never arrived", pending);
    end
    $display("ran %0d pixels through %0d register settings plus reset values,",
             compared, settings_run);
    $display("covering off, alpha blend, white and black fade with clamped weights");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
